// ===== rtl/tcce_pkg.sv =====
// Package for the text console character engine.
// Holds the command codes, character codes, field widths and FSM state types.
// No dependencies.
`default_nettype none

package tcce_pkg;

    // Field widths of the stream payloads
    localparam int CMD_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int CELL_W    = 16;
    localparam int POS_W     = 11;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    // Character codes handled by the put command
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Blank fill for scroll and clear, and the attribute register reset value
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0f20;
    localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h0f;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    // Command sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SWEEP,
        ST_DONE
    } t_ctl_state;

    // Sweep engine states
    typedef enum logic [1:0] {
        SW_IDLE,
        SW_COPY,
        SW_FILL
    } t_sweep_state;

    // Request from the sequencer to the sweep engine
    typedef struct packed {
        logic start;
        logic scroll;   // 1: scroll up one row, 0: blank the whole store
    } t_sweep_cmd;

endpackage

`default_nettype wire

// ===== rtl/tcce_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/tcce_sweep.sv =====
// Sweep engine: walks the screen store to blank it or scroll it up one row.
// Depends on tcce_pkg; drives the ports of the screen RAM during a sweep.
`default_nettype none

module tcce_sweep #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire tcce_pkg::t_sweep_cmd                i_cmd,
    output logic                                     o_done,
    output logic                                     o_we,
    output logic [$clog2(COLUMNS*ROWS)-1:0]          o_waddr,
    output logic [tcce_pkg::CELL_W-1:0]              o_wdata,
    output logic [$clog2(COLUMNS*ROWS)-1:0]          o_raddr,
    input  wire logic [tcce_pkg::CELL_W-1:0]         i_rdata
);
    import tcce_pkg::*;

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int AW       = $clog2(CELLS);
    localparam int COPY_END = (ROWS - 1) * COLUMNS - 1;
    localparam int LAST     = CELLS - 1;

    t_sweep_state    r_state, n_state;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic            r_wr_pend, n_wr_pend;
    logic            r_wr_last, n_wr_last;
    logic            r_wr_blank, n_wr_blank;
    logic [AW-1:0]   r_wr_addr, n_wr_addr;

    // Next state and walk counter
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            SW_IDLE: begin
                if (i_cmd.start) begin
                    n_cnt   = '0;
                    n_state = i_cmd.scroll ? SW_COPY : SW_FILL;
                end
            end
            SW_COPY: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == AW'(COPY_END)) begin
                    n_state = SW_FILL;
                end
            end
            SW_FILL: begin
                if (r_cnt == AW'(LAST)) begin
                    n_state = SW_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: n_state = SW_IDLE;
        endcase
    end

    // Write pipe: each visited cell is written in the next cycle, when read data is back
    always_comb begin
        n_wr_pend  = 1'b0;
        n_wr_last  = 1'b0;
        n_wr_blank = 1'b1;
        n_wr_addr  = r_cnt;
        case (r_state)
            SW_COPY: begin
                n_wr_pend  = 1'b1;
                n_wr_blank = 1'b0;
            end
            SW_FILL: begin
                n_wr_pend = 1'b1;
                n_wr_last = (r_cnt == AW'(LAST));
            end
            default: ;
        endcase
    end

    // Reset starts a blanking pass over the whole store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= SW_FILL;
            r_cnt     <= '0;
            r_wr_pend <= 1'b0;
            r_wr_last <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_wr_pend <= n_wr_pend;
            r_wr_last <= n_wr_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_blank <= n_wr_blank;
        r_wr_addr  <= n_wr_addr;
    end

    // RAM ports: source row is one row below the destination
    assign o_raddr = r_cnt + AW'(COLUMNS);
    assign o_we    = r_wr_pend;
    assign o_waddr = r_wr_addr;
    assign o_wdata = r_wr_blank ? BLANK_CELL : i_rdata;
    assign o_done  = r_wr_pend & r_wr_last;

endmodule

`default_nettype wire

// ===== rtl/text_console_character_engine.sv =====
// Text console character engine top level: command sequencer, cursor and output register.
// Depends on tcce_pkg, tcce_ram (screen store) and tcce_sweep (scroll / clear engine).
//
//  channel   | direction | tdata fields (low bit up)                      | tuser
//  ----------+-----------+------------------------------------------------+---------
//  s_axis    | in        | char_code[7:0] col[14:8] row[19:15] pad[23:20]  | command
//  m_axis    | out       | cell_value[15:0] cursor_col[22:16]              | -
//            |           | cursor_row[27:23] cursor_position[38:28] pad    |
//  i_cfg     | in        | i_cfg_wdata = text_attribute                   | -
//
// From one transaction to the next possible one: an on-screen read passes through an extra
// state (ST_READ) for the registered RAM read; put, set cursor and an off-screen read do not.
// A scroll or a clear runs a sweep over all COLUMNS*ROWS cells; the sweep engine
// moves one cell per cycle through the single RAM write port.
// After reset the store is blanked one cell per cycle and s_axis_tready stays low
// until the blanking pass is done; configuration writes are taken throughout.
// One command is in flight at a time; a finished result may wait in the output
// register while the next command is accepted, and a further result then holds the
// sequencer until m_axis_tready frees the register.
`default_nettype none

module text_console_character_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration: text attribute register
    input  wire logic                             i_cfg_we,
    input  wire logic [tcce_pkg::CHAR_W-1:0]      i_cfg_wdata,
    // Command stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [tcce_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // char_code, col, row
    input  wire logic [tcce_pkg::CMD_W-1:0]       s_axis_tuser,  // command
    // Result stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [tcce_pkg::M_TDATA_W-1:0]        m_axis_tdata   // cell_value, cursor_col,
                                                                 // cursor_row, cursor_position
);
    import tcce_pkg::*;

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int AW       = $clog2(CELLS);
    localparam int CW       = $clog2(COLUMNS);
    localparam int RW       = $clog2(ROWS);
    localparam int LAST_COL = COLUMNS - 1;
    localparam int LAST_ROW = ROWS - 1;

    t_ctl_state          r_state, n_state;
    logic [CW-1:0]       r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic [CHAR_W-1:0]   r_attr;
    logic [CELL_W-1:0]   r_cell;
    logic                r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    t_cmd                w_in_cmd;
    logic [CHAR_W-1:0]   w_in_char;
    logic [COL_W-1:0]    w_in_col;
    logic [ROW_W-1:0]    w_in_row;
    logic                w_accept;
    logic                w_out_load;
    logic [AW-1:0]       w_pos;
    logic                w_scroll;
    logic                w_cmd_we;
    logic [AW-1:0]       w_cmd_waddr;
    logic [CELL_W-1:0]   w_cmd_wdata;
    logic                w_rd_ok;
    logic [AW-1:0]       w_cmd_raddr;

    t_sweep_cmd          w_sw_cmd;
    logic                w_sw_done;
    logic                w_sw_we;
    logic [AW-1:0]       w_sw_waddr;
    logic [CELL_W-1:0]   w_sw_wdata;
    logic [AW-1:0]       w_sw_raddr;

    logic                w_mem_we;
    logic [AW-1:0]       w_mem_waddr;
    logic [CELL_W-1:0]   w_mem_wdata;
    logic [AW-1:0]       w_mem_raddr;
    logic [CELL_W-1:0]   w_mem_rdata;

    // Input unpacking
    assign w_in_cmd  = t_cmd'(s_axis_tuser);
    assign w_in_char = s_axis_tdata[7:0];
    assign w_in_col  = s_axis_tdata[14:8];
    assign w_in_row  = s_axis_tdata[19:15];
    assign w_accept  = s_axis_tvalid & s_axis_tready;

    // Linear cursor position
    assign w_pos = AW'(int'(r_col) + int'(r_row) * COLUMNS);

    // Command decode: new cursor, cell write and read address
    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        w_scroll    = 1'b0;
        w_cmd_we    = 1'b0;
        w_cmd_waddr = w_pos;
        w_cmd_wdata = {r_attr, CH_SPACE};
        w_rd_ok     = (int'(w_in_col) < COLUMNS) && (int'(w_in_row) < ROWS);
        w_cmd_raddr = AW'(int'(w_in_col) + int'(w_in_row) * COLUMNS);
        case (w_in_cmd)
            CMD_PUT: begin
                case (w_in_char)
                    CH_LF: begin
                        n_col = '0;
                        if (r_row == RW'(LAST_ROW)) begin
                            w_scroll = 1'b1;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end
                    CH_CR: begin
                        n_col = '0;
                    end
                    CH_BS: begin
                        // Step back and blank; nothing at column 0
                        if (r_col != '0) begin
                            n_col       = r_col - 1'b1;
                            w_cmd_we    = 1'b1;
                            w_cmd_waddr = w_pos - 1'b1;
                        end
                    end
                    default: begin
                        // Any other code is printed (tab prints a space), advance with wrap
                        w_cmd_we    = 1'b1;
                        w_cmd_wdata = {r_attr, (w_in_char == CH_TAB) ? CH_SPACE : w_in_char};
                        if (r_col == CW'(LAST_COL)) begin
                            n_col = '0;
                            if (r_row == RW'(LAST_ROW)) begin
                                w_scroll = 1'b1;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end
                endcase
            end
            CMD_SET: begin
                n_col = (int'(w_in_col) < COLUMNS) ? CW'(w_in_col) : CW'(LAST_COL);
                n_row = (int'(w_in_row) < ROWS) ? RW'(w_in_row) : RW'(LAST_ROW);
            end
            default: ;
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (w_sw_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_in_cmd)
                        CMD_PUT:   n_state = w_scroll ? ST_SWEEP : ST_DONE;
                        CMD_SET:   n_state = ST_DONE;
                        CMD_CLEAR: n_state = ST_SWEEP;
                        default:   n_state = w_rd_ok ? ST_READ : ST_DONE;
                    endcase
                end
            end
            ST_READ: n_state = ST_DONE;
            ST_SWEEP: begin
                if (w_sw_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_axis_tready   = (r_state == ST_IDLE);
        w_sw_cmd.start  = 1'b0;
        w_sw_cmd.scroll = (w_in_cmd == CMD_PUT);
        w_out_load      = 1'b0;
        w_mem_raddr     = w_cmd_raddr;
        case (r_state)
            ST_IDLE: begin
                w_sw_cmd.start = w_accept &&
                                 ((w_in_cmd == CMD_CLEAR) || ((w_in_cmd == CMD_PUT) && w_scroll));
            end
            ST_INIT, ST_SWEEP: begin
                w_mem_raddr = w_sw_raddr;
            end
            ST_DONE: begin
                w_out_load = !r_out_valid || m_axis_tready;
            end
            default: ;
        endcase
    end

    // RAM write port arbitration: sweep writes never overlap command writes
    assign w_mem_we    = w_sw_we | (w_accept & w_cmd_we);
    assign w_mem_waddr = w_sw_we ? w_sw_waddr : w_cmd_waddr;
    assign w_mem_wdata = w_sw_we ? w_sw_wdata : w_cmd_wdata;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_col       <= '0;
            r_row       <= '0;
            r_attr      <= ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cell <= '0;
        end else if (r_state == ST_READ) begin
            r_cell <= w_mem_rdata;
        end
        if (w_out_load) begin
            r_out_data <= {1'b0, POS_W'(w_pos), ROW_W'(r_row), COL_W'(r_col), r_cell};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    tcce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    tcce_sweep #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_sw_cmd),
        .o_done  (w_sw_done),
        .o_we    (w_sw_we),
        .o_waddr (w_sw_waddr),
        .o_wdata (w_sw_wdata),
        .o_raddr (w_sw_raddr),
        .i_rdata (w_mem_rdata)
    );

`ifndef SYNTHESIS
    // Sweep completion only while the sequencer waits for it
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sw_done |-> (r_state == ST_INIT || r_state == ST_SWEEP))
        else $error("sweep finished outside a sweep wait");

    // Command writes never collide with sweep writes
    a_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_accept && w_cmd_we && w_sw_we))
        else $error("command and sweep write in the same cycle");

    // Cursor stays on screen
    a_cursor_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_col) < COLUMNS) && (int'(r_row) < ROWS))
        else $error("cursor off screen");

    // One command in flight at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("command accepted on consecutive cycles");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_text_console_character_engine.sv =====
// Self-checking testbench for text_console_character_engine.
// Drives commands on s_axis, predicts the screen store and cursor, checks every m_axis result.
// Depends on tcce_pkg and the engine RTL only.
`timescale 1ns / 1ps

module tb_text_console_character_engine;
    import tcce_pkg::*;

    localparam int COLS        = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = COLS * ROWS;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 216;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int HOLD_AT     = 700;   // result count at which the sink holds off
    localparam int HOLD_CYCLES = 400;

    // Cursor report carried on m_axis, cell_value in the low bits
    typedef struct packed {
        logic [POS_W-1:0]  cpos;
        logic [ROW_W-1:0]  crow;
        logic [COL_W-1:0]  ccol;
        logic [CELL_W-1:0] cval;
    } t_cursor_report;

    typedef struct packed {
        t_cmd              cmd;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              known;
        t_cursor_report    want;
    } t_stim_row;

    localparam t_cursor_report NO_WANT = '0;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CHAR_W-1:0]     i_cfg_wdata   = ATTR_RESET;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [CMD_W-1:0]      s_axis_tuser  = CMD_PUT;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    // Shadow of the engine: screen store, cursor and attribute register
    logic [CELL_W-1:0]     screen_copy [0:CELLS-1];
    int                    cur_col;
    int                    cur_row;
    logic [CHAR_W-1:0]     attr_shadow;

    t_cursor_report        expected_reports [$];
    int                    errors      = 0;
    int                    results_in  = 0;
    int                    cycle_count = 0;
    bit                    no_idle     = 1'b0;

    // Directed part: extremes, every command and every put case
    t_stim_row directed_rows [0:24] = '{
        '{CMD_READ,  8'h00,  7'd0,   5'd0,  1'b1,
          '{cval:16'h0f20, ccol:7'd0, crow:5'd0, cpos:11'd0}},
        '{CMD_READ,  8'h00,  7'd79,  5'd24, 1'b1,
          '{cval:16'h0f20, ccol:7'd0, crow:5'd0, cpos:11'd0}},
        '{CMD_READ,  8'hff,  7'd127, 5'd31, 1'b1,
          '{cval:16'h0000, ccol:7'd0, crow:5'd0, cpos:11'd0}},
        '{CMD_READ,  8'h00,  7'd80,  5'd0,  1'b1,
          '{cval:16'h0000, ccol:7'd0, crow:5'd0, cpos:11'd0}},
        '{CMD_READ,  8'h00,  7'd0,   5'd25, 1'b1,
          '{cval:16'h0000, ccol:7'd0, crow:5'd0, cpos:11'd0}},
        '{CMD_SET,   8'h00,  7'd127, 5'd31, 1'b1,
          '{cval:16'h0000, ccol:7'd79, crow:5'd24, cpos:11'd1999}},
        '{CMD_SET,   8'h00,  7'd0,   5'd0,  1'b1,
          '{cval:16'h0000, ccol:7'd0, crow:5'd0, cpos:11'd0}},
        '{CMD_PUT,   8'h41,  7'd0,   5'd0,  1'b1,
          '{cval:16'h0000, ccol:7'd1, crow:5'd0, cpos:11'd1}},
        '{CMD_READ,  8'h00,  7'd0,   5'd0,  1'b1,
          '{cval:16'h0f41, ccol:7'd1, crow:5'd0, cpos:11'd1}},
        '{CMD_PUT,   8'hff,  7'd127, 5'd31, 1'b0, NO_WANT},
        '{CMD_PUT,   8'h00,  7'd0,   5'd0,  1'b0, NO_WANT},
        '{CMD_PUT,   CH_TAB, 7'd0,   5'd0,  1'b0, NO_WANT},
        '{CMD_PUT,   CH_BS,  7'd0,   5'd0,  1'b0, NO_WANT},
        '{CMD_PUT,   CH_CR,  7'd0,   5'd0,  1'b1,
          '{cval:16'h0000, ccol:7'd0, crow:5'd0, cpos:11'd0}},
        '{CMD_PUT,   CH_BS,  7'd0,   5'd0,  1'b1,
          '{cval:16'h0000, ccol:7'd0, crow:5'd0, cpos:11'd0}},
        '{CMD_PUT,   CH_LF,  7'd0,   5'd0,  1'b1,
          '{cval:16'h0000, ccol:7'd0, crow:5'd1, cpos:11'd80}},
        '{CMD_SET,   8'h00,  7'd79,  5'd5,  1'b1,
          '{cval:16'h0000, ccol:7'd79, crow:5'd5, cpos:11'd479}},
        '{CMD_PUT,   8'h7a,  7'd0,   5'd0,  1'b1,
          '{cval:16'h0000, ccol:7'd0, crow:5'd6, cpos:11'd480}},
        '{CMD_SET,   8'h00,  7'd79,  5'd24, 1'b1,
          '{cval:16'h0000, ccol:7'd79, crow:5'd24, cpos:11'd1999}},
        '{CMD_PUT,   8'h23,  7'd0,   5'd0,  1'b1,
          '{cval:16'h0000, ccol:7'd0, crow:5'd24, cpos:11'd1920}},
        '{CMD_READ,  8'h00,  7'd79,  5'd23, 1'b0, NO_WANT},
        '{CMD_PUT,   CH_LF,  7'd0,   5'd0,  1'b1,
          '{cval:16'h0000, ccol:7'd0, crow:5'd24, cpos:11'd1920}},
        '{CMD_READ,  8'h00,  7'd79,  5'd22, 1'b0, NO_WANT},
        '{CMD_CLEAR, 8'h00,  7'd0,   5'd0,  1'b1,
          '{cval:16'h0000, ccol:7'd0, crow:5'd24, cpos:11'd1920}},
        '{CMD_READ,  8'h00,  7'd79,  5'd22, 1'b1,
          '{cval:16'h0f20, ccol:7'd0, crow:5'd24, cpos:11'd1920}}
    };

    text_console_character_engine #(
        .COLUMNS (COLS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // char_code[7:0] col[14:8] row[19:15] pad
        .s_axis_tuser  (s_axis_tuser),   // command
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // cell_value[15:0] cursor_col[22:16]
                                         // cursor_row[27:23] cursor_position[38:28] pad
    );

    always #10 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Cursor to column 0 of the next line, scrolling from the bottom row
    task automatic advance_line();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS) begin
            cur_row = ROWS - 1;
            for (int i = 0; i < (ROWS - 1) * COLS; i++)
                screen_copy[i] = screen_copy[i + COLS];
            for (int i = (ROWS - 1) * COLS; i < CELLS; i++)
                screen_copy[i] = BLANK_CELL;
        end
    endtask

    // Apply one command to the shadow and form the report it should produce
    task automatic predict_console(input t_cmd cmd, input logic [CHAR_W-1:0] ch,
                                   input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                                   output t_cursor_report rep);
        logic [CHAR_W-1:0] glyph;
        rep  = '0;
        glyph = ch;
        case (cmd)
            CMD_PUT: begin
                if (ch == CH_LF) begin
                    advance_line();
                end else if (ch == CH_CR) begin
                    cur_col = 0;
                end else if (ch == CH_BS) begin
                    // nothing happens at the left margin
                    if (cur_col > 0) begin
                        cur_col--;
                        screen_copy[cur_col + cur_row * COLS] = {attr_shadow, CH_SPACE};
                    end
                end else begin
                    if (ch == CH_TAB)
                        glyph = CH_SPACE;
                    screen_copy[cur_col + cur_row * COLS] = {attr_shadow, glyph};
                    if (cur_col >= COLS - 1)
                        advance_line();
                    else
                        cur_col++;
                end
            end
            CMD_SET: begin
                cur_col = (col < COLS) ? int'(col) : COLS - 1;
                cur_row = (row < ROWS) ? int'(row) : ROWS - 1;
            end
            CMD_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen_copy[i] = BLANK_CELL;
            end
            default: begin
                if (col < COLS && row < ROWS)
                    rep.cval = screen_copy[int'(col) + int'(row) * COLS];
            end
        endcase
        rep.ccol = COL_W'(cur_col);
        rep.crow = ROW_W'(cur_row);
        rep.cpos = POS_W'(cur_col + cur_row * COLS);
    endtask

    // Offer one command; on its transaction record the expected report
    task automatic send_command(input t_cmd cmd, input logic [CHAR_W-1:0] ch,
                                input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                                input logic known, input t_cursor_report want);
        int             gap;
        t_cursor_report rep;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, row, col, ch};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        predict_console(cmd, ch, col, row, rep);
        expected_reports.push_back(known ? want : rep);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_attribute(input logic [CHAR_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        attr_shadow = value;
    endtask

    // Result sink: random stalls, one long hold-off, field-by-field compare
    initial begin : result_sink
        int             gap;
        t_cursor_report got;
        t_cursor_report want;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1) @(posedge i_clk);
            got = t_cursor_report'(m_axis_tdata[$bits(t_cursor_report)-1:0]);
            results_in++;
            if (expected_reports.size() == 0) begin
                $display("%0t: result with nothing outstanding, expected none actual %h",
                         $time, got);
                errors++;
            end else begin
                want = expected_reports.pop_front();
                if (got.cval !== want.cval) begin
                    $display("%0t: cell_value expected %h actual %h", $time, want.cval, got.cval);
                    errors++;
                end
                if (got.ccol !== want.ccol) begin
                    $display("%0t: cursor_col expected %0d actual %0d",
                             $time, want.ccol, got.ccol);
                    errors++;
                end
                if (got.crow !== want.crow) begin
                    $display("%0t: cursor_row expected %0d actual %0d",
                             $time, want.crow, got.crow);
                    errors++;
                end
                if (got.cpos !== want.cpos) begin
                    $display("%0t: cursor_position expected %0d actual %0d",
                             $time, want.cpos, got.cpos);
                    errors++;
                end
            end
            // long back-pressure while the source keeps offering
            if (results_in == HOLD_AT) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        t_cmd              cmd;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        int                pick;
        int                scroll_budget;
        int                clear_budget;
        bit                scrolls;

        scroll_budget = 100;
        clear_budget  = 12;
        for (int i = 0; i < CELLS; i++)
            screen_copy[i] = BLANK_CELL;
        cur_col     = 0;
        cur_row     = 0;
        attr_shadow = ATTR_RESET;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_command(directed_rows[k].cmd, directed_rows[k].ch, directed_rows[k].col,
                         directed_rows[k].row, directed_rows[k].known, directed_rows[k].want);

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0:       write_attribute(8'h00);
                1:       write_attribute(8'hff);
                default: write_attribute(CHAR_W'($urandom_range(0, 255)));
            endcase
            no_idle = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                ch   = CHAR_W'($urandom_range(0, 255));
                col  = COL_W'($urandom_range(0, COLS - 1));
                row  = ROW_W'($urandom_range(0, ROWS - 1));
                if (pick < 60) begin
                    cmd = CMD_PUT;
                    case ($urandom_range(0, 9))
                        0:       ch = CH_LF;
                        1:       ch = CH_CR;
                        2:       ch = CH_BS;
                        3:       ch = CH_TAB;
                        default: ;
                    endcase
                    // scrolls are slow: keep them within budget
                    scrolls = (cur_row == ROWS - 1) &&
                              (ch == CH_LF || (ch != CH_CR && ch != CH_BS &&
                                               cur_col == COLS - 1));
                    if (scrolls) begin
                        if (scroll_budget > 0)
                            scroll_budget--;
                        else
                            ch = CH_CR;
                    end
                end else if (pick < 70) begin
                    cmd = CMD_SET;
                    if ($urandom_range(0, 4) == 0) begin
                        col = COL_W'($urandom_range(0, 127));
                        row = ROW_W'($urandom_range(0, 31));
                    end else begin
                        if ($urandom_range(0, 3) == 0)
                            col = COL_W'(COLS - 1);
                        if ($urandom_range(0, 2) == 0)
                            row = ROW_W'(ROWS - 1);
                    end
                end else if (pick < 99 || clear_budget == 0) begin
                    cmd = CMD_READ;
                    if ($urandom_range(0, 4) == 0) begin
                        col = COL_W'($urandom_range(0, 127));
                        row = ROW_W'($urandom_range(0, 31));
                    end
                end else begin
                    cmd = CMD_CLEAR;
                    clear_budget--;
                end
                send_command(cmd, ch, col, row, 1'b0, NO_WANT);
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tcce_pkg.sv
rtl/tcce_ram.sv
rtl/tcce_sweep.sv
rtl/text_console_character_engine.sv
verif/tb_text_console_character_engine.sv
